[hw/rtl/rllt_pkg.sv]
// shared types and constants of the run-length line table
package rllt_pkg;

  localparam int unsigned MAX_RUNS  = 256;
  localparam int unsigned MAX_BYTES = 65536;

  localparam int unsigned RUN_AW  = $clog2(MAX_RUNS);
  localparam int unsigned RUN_CW  = $clog2(MAX_RUNS + 1);
  localparam int unsigned BYTE_CW = $clog2(MAX_BYTES + 1);
  localparam int unsigned LINE_W  = 16;
  localparam int unsigned OFS_W   = 16;
  localparam int unsigned ENTRY_W = OFS_W + LINE_W;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic              req_type;
    logic [LINE_W-1:0] source_line;
    logic [OFS_W-1:0]  query_offset;
  } req_t;

  typedef struct packed {
    logic [LINE_W-1:0] found_line;
    status_t           status;
  } rsp_t;

  typedef struct packed {
    logic [OFS_W-1:0]  start_ofs;
    logic [LINE_W-1:0] line;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic append;
    logic empty;
    logic rd;
    logic step;
    logic final_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_append;
    logic is_empty;
    logic search_done;
  } sts_t;

endpackage

[hw/rtl/rllt_ram.sv]
// generic single write port ram with registered read
module rllt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/rllt_ctrl.sv]
// sequencer for append and binary-search lookup
module rllt_ctrl
  import rllt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_PROBE,
    S_FINAL
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_append) begin
          cmd.append = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sts.is_empty) begin
          cmd.empty = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = sts.search_done ? S_FINAL : S_PROBE;
        end
      end
      S_PROBE: begin
        // narrow the window on the word just read and issue the next read
        cmd.step  = 1'b1;
        cmd.rd    = 1'b1;
        state_nxt = sts.search_done ? S_FINAL : S_PROBE;
      end
      S_FINAL: begin
        cmd.final_out = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

[hw/rtl/rllt_dp.sv]
// datapath: run table, counters, search window and result register
module rllt_dp
  import rllt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  req_t in_req,
  input  cmd_t cmd,
  output sts_t sts,
  output logic out_valid,
  output rsp_t out_rsp
);

  req_t               req_r;
  logic [RUN_AW-1:0]  lo_r, hi_r, mid_r;
  logic [RUN_CW-1:0]  run_count_r;
  logic [BYTE_CW-1:0] byte_count_r;
  logic [LINE_W-1:0]  last_line_r;
  logic               out_valid_r;
  rsp_t               out_rsp_r;

  entry_t             rd_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic [RUN_AW-1:0]  lo_nxt, hi_nxt, mid_nxt, rd_addr, hi_load;
  logic [RUN_AW:0]    mid_sum;
  logic               probe_le, done;
  logic               byte_full, run_full, same_line, do_write;
  entry_t             wr_entry;

  assign rd_entry = entry_t'(rd_data);
  assign probe_le = (rd_entry.start_ofs <= req_r.query_offset);

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.step) begin
      if (probe_le) begin
        lo_nxt = mid_r;
      end else begin
        hi_nxt = mid_r - RUN_AW'(1);
      end
    end
  end

  assign done    = (lo_nxt >= hi_nxt);
  // upper middle of the window
  assign mid_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt} + (RUN_AW + 1)'(1);
  assign mid_nxt = mid_sum[RUN_AW:1];
  assign rd_addr = done ? lo_nxt : mid_nxt;
  assign hi_load = RUN_AW'(run_count_r - RUN_CW'(1));

  assign byte_full = (byte_count_r >= BYTE_CW'(MAX_BYTES));
  assign run_full  = (run_count_r >= RUN_CW'(MAX_RUNS));
  assign same_line = (run_count_r != '0) && (last_line_r == req_r.source_line);
  assign do_write  = cmd.append && !byte_full && !same_line && !run_full;

  assign wr_entry.start_ofs = byte_count_r[OFS_W-1:0];
  assign wr_entry.line      = req_r.source_line;

  rllt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_RUNS)
  ) u_ram (
    .clk  (clk),
    .we   (do_write),
    .waddr(run_count_r[RUN_AW-1:0]),
    .wdata(wr_entry),
    .re   (cmd.rd),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  assign sts.is_append   = (req_r.req_type == REQ_APPEND);
  assign sts.is_empty    = (run_count_r == '0);
  assign sts.search_done = done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_count_r  <= '0;
      byte_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.append || cmd.empty || cmd.final_out;
      if (cmd.append && !byte_full) begin
        if (same_line) begin
          byte_count_r <= byte_count_r + BYTE_CW'(1);
        end else if (!run_full) begin
          run_count_r  <= run_count_r + RUN_CW'(1);
          byte_count_r <= byte_count_r + BYTE_CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
      lo_r  <= '0;
      hi_r  <= hi_load;
    end
    if (cmd.rd) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= rd_addr;
    end
    if (do_write) begin
      last_line_r <= req_r.source_line;
    end
    if (cmd.append) begin
      out_rsp_r.found_line <= '0;
      if (byte_full || (!same_line && run_full)) begin
        out_rsp_r.status <= ST_FULL;
      end else begin
        out_rsp_r.status <= ST_OK;
      end
    end else if (cmd.empty) begin
      out_rsp_r.found_line <= '0;
      out_rsp_r.status     <= ST_EMPTY;
    end else if (cmd.final_out) begin
      out_rsp_r.found_line <= rd_entry.line;
      out_rsp_r.status     <= ST_OK;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

[hw/rtl/run_length_line_table_unit.sv]
// run-length line table: top level joining controller and datapath
// append or empty-table lookup: decide state, then the result strobe
// lookup: decide state, a probe state for each halving of the run window, one final state,
//   then the strobe; the probes run one after another on the one ram read port
// a new item is taken at the edge that ends the result strobe
// reset: synchronous active-low rst_n clears run and byte counts and the sequencer;
//   table contents stay undefined, no clearing pass; the receiver cannot stall
module run_length_line_table_unit
  import rllt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output rsp_t out_rsp
);

  cmd_t cmd;
  sts_t sts;

  rllt_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  rllt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  // an accepted transfer keeps the unit busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  // a result only follows work in progress and lands as the unit frees up
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe without preceding work");

  // empty-table answers carry no line
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.status == ST_EMPTY) |-> (out_rsp.found_line == '0))
    else $error("empty status with nonzero line");

  // no invalid status code ever leaves the unit
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.status == ST_OK || out_rsp.status == ST_FULL ||
                   out_rsp.status == ST_EMPTY))
    else $error("bad status code");

endmodule

[tb/tb_top.sv]
// self-checking testbench for the run-length line table: directed rows, random items, full table
`timescale 1ns / 100ps

module tb_top;
  import rllt_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 500;
  localparam int unsigned MAX_GAP = 12;
  localparam int DIR_N = 22;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  req_t  in_req;
  logic  out_valid;
  rsp_t  out_rsp;

  // directed stimulus row; typed rows carry the answer, the rest go to the predictor
  typedef struct packed {
    req_kind_t         kind;
    logic [LINE_W-1:0] line;
    logic [OFS_W-1:0]  ofs;
    logic              typed;
    logic [LINE_W-1:0] want_line;
    status_t           want_st;
  } row_t;

  row_t plan [DIR_N];

  // predictor copy of the table
  logic [OFS_W-1:0]  run_start [MAX_RUNS];
  logic [LINE_W-1:0] run_line  [MAX_RUNS];
  int unsigned       runs_used;
  int unsigned       bytes_used;

  rsp_t        pending_lines [$];
  logic        typed_valid;
  rsp_t        typed_rsp;
  int unsigned errors;
  int unsigned stall_cycles;
  int unsigned n_items, n_lookups, n_empty, n_refused;

  run_length_line_table_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic rsp_t predict_line(input req_t r);
    rsp_t res;
    int unsigned lo, hi, mid;
    res.found_line = '0;
    res.status = ST_OK;
    if (r.req_type == REQ_APPEND) begin
      if (bytes_used >= MAX_BYTES) begin
        res.status = ST_FULL;
      end else if (runs_used > 0 && run_line[runs_used-1] == r.source_line) begin
        bytes_used++;
      end else if (runs_used >= MAX_RUNS) begin
        res.status = ST_FULL;
      end else begin
        run_start[runs_used] = 16'(bytes_used);
        run_line[runs_used] = r.source_line;
        runs_used++;
        bytes_used++;
      end
    end else if (runs_used == 0) begin
      res.status = ST_EMPTY;
    end else begin
      lo = 0;
      hi = runs_used - 1;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (run_start[mid] <= r.query_offset) lo = mid;
        else hi = mid - 1;
      end
      res.found_line = run_line[lo];
    end
    return res;
  endfunction

  // mostly well-formed: appends that extend the newest run, lookups near run boundaries
  function automatic req_t pick_line_req();
    req_t r;
    int unsigned k;
    r.source_line = 16'($urandom);
    r.query_offset = 16'($urandom);
    if ($urandom_range(99) < 55) begin
      r.req_type = REQ_APPEND;
      if (runs_used > 0 && $urandom_range(99) < 65) begin
        r.source_line = run_line[runs_used-1];
      end else if ($urandom_range(9) == 0) begin
        r.source_line = $urandom_range(1) ? 16'hffff : 16'h0000;
      end
    end else begin
      r.req_type = REQ_LOOKUP;
      k = $urandom_range(99);
      if (runs_used > 0 && k < 40) begin
        r.query_offset = run_start[$urandom_range(runs_used - 1)];
        if ($urandom_range(1)) r.query_offset = r.query_offset - 16'd1;
      end else if (k < 80) begin
        r.query_offset = 16'($urandom_range(bytes_used + 2));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input rsp_t got, input rsp_t want);
    $display("tb_top: mismatch on %s: got line %h status %0d, want line %h status %0d",
             what, got.found_line, got.status, want.found_line, want.status);
    errors++;
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input req_t r, input int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
      gap++;
    end
    start = 1'b1;
    in_req = r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : monitor
    rsp_t want;
    rsp_t pred;
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid) begin
        moved = 1'b1;
        if (pending_lines.size() == 0) begin
          want = '0;
          report_mismatch("result with nothing pending", out_rsp, want);
        end else begin
          want = pending_lines.pop_front();
          if (out_rsp.found_line !== want.found_line) report_mismatch("found_line", out_rsp, want);
          if (out_rsp.status !== want.status) report_mismatch("status", out_rsp, want);
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        pred = predict_line(in_req);
        if (typed_valid) pred = typed_rsp;
        pending_lines.push_back(pred);
        n_items++;
        if (in_req.req_type == REQ_LOOKUP) n_lookups++;
        if (pred.status == ST_EMPTY) n_empty++;
        if (pred.status == ST_FULL) n_refused++;
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_top: no transfer for %0d cycles", STALL_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    req_t r;
    int unsigned phase_idle [3];
    start = 1'b0;
    in_req = '0;
    rst_n = 1'b0;
    typed_valid = 1'b0;
    typed_rsp = '0;
    runs_used = 0;
    bytes_used = 0;
    errors = 0;
    stall_cycles = 0;
    n_items = 0;
    n_lookups = 0;
    n_empty = 0;
    n_refused = 0;
    phase_idle = '{34, 74, 0};

    plan = '{
      '{REQ_LOOKUP, 16'h0000, 16'h0000, 1'b1, 16'h0000, ST_EMPTY},
      '{REQ_LOOKUP, 16'hffff, 16'hffff, 1'b1, 16'h0000, ST_EMPTY},
      '{REQ_APPEND, 16'h0000, 16'hffff, 1'b1, 16'h0000, ST_OK},
      '{REQ_APPEND, 16'h0000, 16'h0000, 1'b1, 16'h0000, ST_OK},
      '{REQ_LOOKUP, 16'hffff, 16'h0000, 1'b1, 16'h0000, ST_OK},
      // past the last byte: newest run answers
      '{REQ_LOOKUP, 16'h0000, 16'hffff, 1'b1, 16'h0000, ST_OK},
      '{REQ_APPEND, 16'hffff, 16'h0000, 1'b1, 16'h0000, ST_OK},
      '{REQ_LOOKUP, 16'h0000, 16'h0001, 1'b1, 16'h0000, ST_OK},
      '{REQ_LOOKUP, 16'h0000, 16'h0002, 1'b1, 16'hffff, ST_OK},
      '{REQ_LOOKUP, 16'h0000, 16'hffff, 1'b1, 16'hffff, ST_OK},
      '{REQ_APPEND, 16'h8000, 16'hffff, 1'b1, 16'h0000, ST_OK},
      '{REQ_APPEND, 16'h0001, 16'h5555, 1'b1, 16'h0000, ST_OK},
      '{REQ_APPEND, 16'h0001, 16'haaaa, 1'b1, 16'h0000, ST_OK},
      '{REQ_APPEND, 16'h0000, 16'h0000, 1'b1, 16'h0000, ST_OK},
      '{REQ_LOOKUP, 16'h0000, 16'h0003, 1'b0, 16'h0000, ST_OK},
      '{REQ_LOOKUP, 16'h0000, 16'h0004, 1'b0, 16'h0000, ST_OK},
      '{REQ_LOOKUP, 16'h0000, 16'h0005, 1'b0, 16'h0000, ST_OK},
      '{REQ_LOOKUP, 16'h0000, 16'h0006, 1'b0, 16'h0000, ST_OK},
      '{REQ_LOOKUP, 16'h0000, 16'h0007, 1'b0, 16'h0000, ST_OK},
      '{REQ_APPEND, 16'hffff, 16'h0000, 1'b1, 16'h0000, ST_OK},
      '{REQ_LOOKUP, 16'h0000, 16'h7fff, 1'b0, 16'h0000, ST_OK},
      '{REQ_LOOKUP, 16'hffff, 16'h0000, 1'b1, 16'h0000, ST_OK}
    };

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      r.req_type = plan[i].kind;
      r.source_line = plan[i].line;
      r.query_offset = plan[i].ofs;
      typed_valid = plan[i].typed;
      typed_rsp.found_line = plan[i].want_line;
      typed_rsp.status = plan[i].want_st;
      send_item(r, 0);
    end
    typed_valid = 1'b0;

    // random items in three idling phases
    for (int p = 0; p < 3; p++) begin
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(pick_line_req(), phase_idle[p]);
      end
    end

    // open runs until the table is full, then one refused new run
    r.query_offset = '0;
    r.req_type = REQ_APPEND;
    while (runs_used < MAX_RUNS) begin
      r.source_line = run_line[runs_used-1] + 16'd1;
      send_item(r, 10);
    end
    r.source_line = run_line[runs_used-1] + 16'd7;
    send_item(r, 0);

    // full table: new lines refused, same-line appends and lookups still answer
    for (int n = 0; n < 60; n++) begin
      send_item(pick_line_req(), 20);
    end
    r.req_type = REQ_APPEND;
    r.source_line = run_line[runs_used-1];
    send_item(r, 0);
    r.req_type = REQ_LOOKUP;
    r.query_offset = 16'hffff;
    send_item(r, 0);
    r.query_offset = 16'h0000;
    send_item(r, 0);
    start = 1'b0;

    while (pending_lines.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("tb_top: %0d items, %0d lookups, %0d empty-table answers, %0d refused appends",
             n_items, n_lookups, n_empty, n_refused);
    $display("tb_top: table ended with %0d runs and %0d bytes", runs_used, bytes_used);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
